// ----- design/complex_arithmetic_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion shorthands clocked on clk_i and reset by rst_ni.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// label, clock, active-low reset, property
`define CAU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("complex arithmetic unit check failed");

// label, property on the unit clock and reset
`define CAU_ASSERT_CLK(lbl, prop) `CAU_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

// ----- design/cau_pkg.sv -----
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Word formats, operation and status codes, saturation helper.
// ---------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IO_BITS     = 32;
  localparam int KIND_BITS   = 3;
  localparam int STATUS_BITS = 2;

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = 2 * WORD_BITS + 1;
  localparam int DW = 2 * WORD_BITS + FRAC_BITS;
  localparam int CW = (WORD_BITS + FRAC_BITS > PW) ? WORD_BITS + FRAC_BITS : PW;

  localparam int LATENCY = WORD_BITS + 5;

  localparam logic [WORD_BITS-1:0] MIN_VAL = WORD_BITS'(1) << (WORD_BITS - 1);
  localparam logic [WORD_BITS-1:0] MAX_VAL = ~MIN_VAL;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_CMP = 3'd4
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SAT  = 2'd1,
    STATUS_DIV0 = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic signed [IO_BITS-1:0] a_real;
    logic signed [IO_BITS-1:0] a_imag;
    logic signed [IO_BITS-1:0] b_real;
    logic signed [IO_BITS-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [IO_BITS-1:0] res_real;
    logic signed [IO_BITS-1:0] res_imag;
    logic                      equal;
    status_e                   status;
  } out_t;

  typedef struct packed {
    logic                 sat;
    logic [WORD_BITS-1:0] val;
  } sat_t;

  function automatic sat_t sat_word(input logic signed [SW-1:0] x);
    logic [SW-WORD_BITS:0] hi;
    sat_t r;
    hi = x[SW-1:WORD_BITS-1];
    if ((&hi) || !(|hi)) begin
      r.sat = 1'b0;
      r.val = x[WORD_BITS-1:0];
    end else begin
      r.sat = 1'b1;
      r.val = x[SW-1] ? MIN_VAL : MAX_VAL;
    end
    return r;
  endfunction

endpackage

// ----- design/complex_arithmetic_unit.sv -----
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined add, subtract, multiply, divide and compare on Q16.16 complex words.
// ---------------------------------------------------------------------------
//  channel  | ports                   | direction | handshake
//  operands | start_i, busy_o, op_i   | in        | start_i && !busy_o
//  result   | valid_o, res_o          | out       | valid_o, one cycle, no hold
//
//  An accepted word passes through stage 1, stage 2, stage 3, the divider chain and the output register before valid_o.
//  One word enters every cycle; busy_o stays low.
//  The divider chain is a restoring divider: one quotient bit per stage.
//  Reset clears every valid bit; payload registers are not reset.
module complex_arithmetic_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cau_pkg::in_t  op_i,
  output logic          valid_o,
  output cau_pkg::out_t res_o
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int PW = cau_pkg::PW;
  localparam int SW = cau_pkg::SW;
  localparam int DW = cau_pkg::DW;
  localparam int CW = cau_pkg::CW;

  typedef struct packed {
    logic [PW-1:0] rem;
    logic [W-1:0]  dlo;
    logic [W-1:0]  q;
  } step_t;

  typedef struct packed {
    logic [cau_pkg::KIND_BITS-1:0] kind;
    logic [W-1:0]                  er;
    logic [W-1:0]                  ei;
    logic                          eq;
    logic                          esat;
    logic [PW-1:0]                 den;
    logic                          den0;
    logic                          neg_r;
    logic                          neg_i;
    logic                          ovf_r;
    logic                          ovf_i;
    step_t                         sr;
    step_t                         si;
  } dv_t;

  function automatic step_t div_step(input step_t s, input logic [PW-1:0] den);
    logic [PW:0] t;
    step_t r;
    t = {s.rem, s.dlo[W-1]};
    if (t >= {1'b0, den}) begin
      r.rem = PW'(t - {1'b0, den});
      r.q   = {s.q[W-2:0], 1'b1};
    end else begin
      r.rem = t[PW-1:0];
      r.q   = {s.q[W-2:0], 1'b0};
    end
    r.dlo = {s.dlo[W-2:0], 1'b0};
    return r;
  endfunction

  function automatic dv_t dv_adv(input dv_t x);
    dv_t r;
    r    = x;
    r.sr = div_step(x.sr, x.den);
    r.si = div_step(x.si, x.den);
    return r;
  endfunction

  // stage 1: operand word
  logic         s1_v_q;
  cau_pkg::in_t s1_q;

  // stage 2: products
  logic                          s2_v_q;
  logic [cau_pkg::KIND_BITS-1:0] s2_kind_q;
  logic                          s2_eq_q;
  logic signed [W:0]             s2_sr_q, s2_si_q;
  logic signed [PW-1:0]          s2_prr_q, s2_pii_q, s2_pri_q, s2_pir_q;
  logic [PW-1:0]                 s2_sqr_q, s2_sqi_q;
  logic signed [W-1:0]           ar, ai, br, bi;
  logic signed [W:0]             s2_sr_d, s2_si_d;

  // stage 3: sums of products
  logic                          s3_v_q;
  logic [cau_pkg::KIND_BITS-1:0] s3_kind_q;
  logic                          s3_eq_q;
  logic signed [W:0]             s3_sr_q, s3_si_q;
  logic signed [SW-1:0]          s3_mr_q, s3_mi_q, s3_nr_q, s3_ni_q;
  logic [PW-1:0]                 s3_den_q;

  // divider chain
  logic dv_v_q [W+1];
  dv_t  dv_q   [W+1];
  dv_t  dv_d;

  logic                 valid_q;
  cau_pkg::out_t        res_q, res_d;

  logic signed [SW-1:0] mr_sh, mi_sh;
  cau_pkg::sat_t        sat_r, sat_i;
  logic [PW-1:0]        mag_r, mag_i;
  logic [DW-1:0]        dd_r, dd_i;
  logic [CW-1:0]        top_r, top_i;
  dv_t                  dl;
  logic                 fsat_r, fsat_i;
  logic [W-1:0]         fv_r, fv_i;

  assign busy_o = 1'b0;

  assign ar = s1_q.a_real[W-1:0];
  assign ai = s1_q.a_imag[W-1:0];
  assign br = s1_q.b_real[W-1:0];
  assign bi = s1_q.b_imag[W-1:0];

  always_comb begin
    if (s1_q.kind == cau_pkg::KIND_SUB) begin
      s2_sr_d = (W+1)'(ar) - (W+1)'(br);
      s2_si_d = (W+1)'(ai) - (W+1)'(bi);
    end else begin
      s2_sr_d = (W+1)'(ar) + (W+1)'(br);
      s2_si_d = (W+1)'(ai) + (W+1)'(bi);
    end
  end

  // stage 4: saturate direct results, set up division
  always_comb begin
    mr_sh  = s3_mr_q >>> F;
    mi_sh  = s3_mi_q >>> F;
    mag_r  = s3_nr_q[SW-1] ? PW'(-s3_nr_q) : PW'(s3_nr_q);
    mag_i  = s3_ni_q[SW-1] ? PW'(-s3_ni_q) : PW'(s3_ni_q);
    dd_r   = DW'(mag_r) << F;
    dd_i   = DW'(mag_i) << F;
    top_r  = CW'(dd_r[DW-1:W]);
    top_i  = CW'(dd_i[DW-1:W]);
    sat_r  = '0;
    sat_i  = '0;
    dv_d   = '0;
    dv_d.kind  = s3_kind_q;
    dv_d.den   = s3_den_q;
    dv_d.den0  = (s3_den_q == '0);
    dv_d.neg_r = s3_nr_q[SW-1];
    dv_d.neg_i = s3_ni_q[SW-1];
    dv_d.ovf_r = top_r >= CW'(s3_den_q);
    dv_d.ovf_i = top_i >= CW'(s3_den_q);
    dv_d.sr.rem = top_r[PW-1:0];
    dv_d.si.rem = top_i[PW-1:0];
    dv_d.sr.dlo = dd_r[W-1:0];
    dv_d.si.dlo = dd_i[W-1:0];
    unique case (s3_kind_q)
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB: begin
        sat_r = cau_pkg::sat_word(SW'(s3_sr_q));
        sat_i = cau_pkg::sat_word(SW'(s3_si_q));
      end
      cau_pkg::KIND_MUL: begin
        sat_r = cau_pkg::sat_word(mr_sh);
        sat_i = cau_pkg::sat_word(mi_sh);
      end
      cau_pkg::KIND_CMP: dv_d.eq = s3_eq_q;
      default: ;
    endcase
    dv_d.er   = sat_r.val;
    dv_d.ei   = sat_i.val;
    dv_d.esat = sat_r.sat | sat_i.sat;
  end

  // output stage: finish division
  always_comb begin
    dl     = dv_q[W];
    fsat_r = dl.ovf_r || (dl.neg_r ? (dl.sr.q[W-1] && |dl.sr.q[W-2:0]) : dl.sr.q[W-1]);
    fsat_i = dl.ovf_i || (dl.neg_i ? (dl.si.q[W-1] && |dl.si.q[W-2:0]) : dl.si.q[W-1]);
    if (fsat_r) fv_r = dl.neg_r ? cau_pkg::MIN_VAL : cau_pkg::MAX_VAL;
    else        fv_r = dl.neg_r ? W'(-dl.sr.q) : dl.sr.q;
    if (fsat_i) fv_i = dl.neg_i ? cau_pkg::MIN_VAL : cau_pkg::MAX_VAL;
    else        fv_i = dl.neg_i ? W'(-dl.si.q) : dl.si.q;
    res_d        = '0;
    res_d.equal  = dl.eq;
    res_d.status = cau_pkg::STATUS_OK;
    if (dl.kind == cau_pkg::KIND_DIV) begin
      if (dl.den0) begin
        res_d.status = cau_pkg::STATUS_DIV0;
      end else begin
        res_d.res_real = cau_pkg::IO_BITS'(signed'(fv_r));
        res_d.res_imag = cau_pkg::IO_BITS'(signed'(fv_i));
        if (fsat_r || fsat_i) res_d.status = cau_pkg::STATUS_SAT;
      end
    end else begin
      res_d.res_real = cau_pkg::IO_BITS'(signed'(dl.er));
      res_d.res_imag = cau_pkg::IO_BITS'(signed'(dl.ei));
      if (dl.esat) res_d.status = cau_pkg::STATUS_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      valid_q <= 1'b0;
      for (int k = 0; k <= W; k++) dv_v_q[k] <= 1'b0;
    end else begin
      s1_v_q    <= start_i && !busy_o;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      dv_v_q[0] <= s3_v_q;
      for (int k = 0; k < W; k++) dv_v_q[k+1] <= dv_v_q[k];
      valid_q   <= dv_v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= op_i;
    s2_kind_q <= s1_q.kind;
    s2_eq_q   <= (ar == br) && (ai == bi);
    s2_sr_q   <= s2_sr_d;
    s2_si_q   <= s2_si_d;
    s2_prr_q  <= PW'(ar) * PW'(br);
    s2_pii_q  <= PW'(ai) * PW'(bi);
    s2_pri_q  <= PW'(ar) * PW'(bi);
    s2_pir_q  <= PW'(ai) * PW'(br);
    s2_sqr_q  <= PW'(PW'(br) * PW'(br));
    s2_sqi_q  <= PW'(PW'(bi) * PW'(bi));
    s3_kind_q <= s2_kind_q;
    s3_eq_q   <= s2_eq_q;
    s3_sr_q   <= s2_sr_q;
    s3_si_q   <= s2_si_q;
    s3_mr_q   <= SW'(s2_prr_q) - SW'(s2_pii_q);
    s3_mi_q   <= SW'(s2_pri_q) + SW'(s2_pir_q);
    s3_nr_q   <= SW'(s2_prr_q) + SW'(s2_pii_q);
    s3_ni_q   <= SW'(s2_pir_q) - SW'(s2_pri_q);
    s3_den_q  <= s2_sqr_q + s2_sqi_q;
    dv_q[0]   <= dv_d;
    for (int k = 0; k < W; k++) dv_q[k+1] <= dv_adv(dv_q[k]);
    res_q     <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ----- design/cau_checker.sv -----
// ---------------------------------------------------------------------------
// Complex arithmetic unit checker
// Port-level checks on latency and result coding, bound to the top level.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input cau_pkg::in_t  op_i,
  input logic          valid_o,
  input cau_pkg::out_t res_o
);

  `CAU_ASSERT_CLK(a_word_out, start_i && !busy_o |-> ##(cau_pkg::LATENCY) valid_o)
  `CAU_ASSERT_CLK(a_no_phantom, !(start_i && !busy_o) |-> ##(cau_pkg::LATENCY) !valid_o)
  `CAU_ASSERT_CLK(a_div0_zero, valid_o && res_o.status == cau_pkg::STATUS_DIV0 |-> res_o.res_real == '0 && res_o.res_imag == '0 && !res_o.equal)
  `CAU_ASSERT_CLK(a_equal_ok, valid_o && res_o.equal |-> res_o.status == cau_pkg::STATUS_OK && res_o.res_real == '0 && res_o.res_imag == '0)

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
